>>> rtl/kbu_pkg.sv
// Shared types, constants and kana code tables for the JIS X0201 to UTF-8 encoder.
package kbu_pkg;

    localparam int unsigned ByteW       = 8;
    localparam int unsigned CodeW       = 24;
    localparam int unsigned MaxResults  = 4;
    localparam int unsigned CountW      = $clog2(MaxResults + 1);

    localparam logic [ByteW-1:0] ByteNul     = 8'h00;
    localparam logic [ByteW-1:0] AsciiFirst  = 8'h20;
    localparam logic [ByteW-1:0] AsciiLast   = 8'h7F;
    localparam logic [ByteW-1:0] KanaFirst   = 8'hA1;
    localparam logic [ByteW-1:0] KanaLast    = 8'hDD;
    localparam logic [ByteW-1:0] MarkVoiced  = 8'hDE;
    localparam logic [ByteW-1:0] MarkSemi    = 8'hDF;
    localparam logic [ByteW-1:0] KanaVu      = 8'hB3;
    localparam logic [ByteW-1:0] KanaKtFirst = 8'hB6;
    localparam logic [ByteW-1:0] KanaKtLast  = 8'hC4;
    localparam logic [ByteW-1:0] KanaHFirst  = 8'hCA;
    localparam logic [ByteW-1:0] KanaHLast   = 8'hCE;
    localparam logic [CodeW-1:0] CodeVu      = 24'hE383B4;
    localparam logic [CodeW-1:0] CodeNone    = 24'h000000;

    localparam logic [CodeW-1:0] KanaBase [0:60] = '{
        24'hE38082, 24'hE3808C, 24'hE3808D, 24'hE38081, 24'hE383BB, 24'hE383B2,
        24'hE382A1, 24'hE382A3, 24'hE382A5, 24'hE382A7, 24'hE382A9, 24'hE383A3,
        24'hE383A5, 24'hE383A7, 24'hE38383, 24'hE383BC, 24'hE382A2, 24'hE382A4,
        24'hE382A6, 24'hE382A8, 24'hE382AA, 24'hE382AB, 24'hE382AD, 24'hE382AF,
        24'hE382B1, 24'hE382B3, 24'hE382B5, 24'hE382B7, 24'hE382B9, 24'hE382BB,
        24'hE382BD, 24'hE382BF, 24'hE38381, 24'hE38384, 24'hE38386, 24'hE38388,
        24'hE3838A, 24'hE3838B, 24'hE3838C, 24'hE3838D, 24'hE3838E, 24'hE3838F,
        24'hE38392, 24'hE38395, 24'hE38398, 24'hE3839B, 24'hE3839E, 24'hE3839F,
        24'hE383A0, 24'hE383A1, 24'hE383A2, 24'hE383A4, 24'hE383A6, 24'hE383A8,
        24'hE383A9, 24'hE383AA, 24'hE383AB, 24'hE383AC, 24'hE383AD, 24'hE383AF,
        24'hE383B3
    };

    localparam logic [CodeW-1:0] KanaVoicedKt [0:14] = '{
        24'hE382AC, 24'hE382AE, 24'hE382B0, 24'hE382B2, 24'hE382B4, 24'hE382B6,
        24'hE382B8, 24'hE382BA, 24'hE382BC, 24'hE382BE, 24'hE38380, 24'hE38382,
        24'hE38385, 24'hE38387, 24'hE38389
    };

    localparam logic [CodeW-1:0] KanaVoicedH [0:4] = '{
        24'hE38390, 24'hE38393, 24'hE38396, 24'hE38399, 24'hE3839C
    };

    localparam logic [CodeW-1:0] KanaSemiH [0:4] = '{
        24'hE38391, 24'hE38394, 24'hE38397, 24'hE3839A, 24'hE3839D
    };

    // Held kana state carried from one word to the next.
    typedef struct packed {
        logic             valid;
        logic [ByteW-1:0] kana;
    } kbu_hold_t;

    // Result words produced by one input word, lowest index sent first.
    typedef struct packed {
        logic [MaxResults-1:0][ByteW-1:0] bytes;
        logic [CountW-1:0]                count;
    } kbu_result_t;

    function automatic logic is_kana(input logic [ByteW-1:0] b);
        return (b >= KanaFirst) && (b <= KanaLast);
    endfunction

    function automatic logic [CodeW-1:0] base_code(input logic [ByteW-1:0] b);
        logic [ByteW-1:0] off;
        off = b - KanaFirst;
        if (is_kana(b)) begin
            return KanaBase[off[5:0]];
        end
        return CodeNone;
    endfunction

    function automatic logic [CodeW-1:0] voiced_code(input logic [ByteW-1:0] b);
        logic [ByteW-1:0] off_kt;
        logic [ByteW-1:0] off_h;
        off_kt = b - KanaKtFirst;
        off_h  = b - KanaHFirst;
        if (b == KanaVu) begin
            return CodeVu;
        end
        if ((b >= KanaKtFirst) && (b <= KanaKtLast)) begin
            return KanaVoicedKt[off_kt[3:0]];
        end
        if ((b >= KanaHFirst) && (b <= KanaHLast)) begin
            return KanaVoicedH[off_h[2:0]];
        end
        return CodeNone;
    endfunction

    function automatic logic [CodeW-1:0] semi_code(input logic [ByteW-1:0] b);
        logic [ByteW-1:0] off_h;
        off_h = b - KanaHFirst;
        if ((b >= KanaHFirst) && (b <= KanaHLast)) begin
            return KanaSemiH[off_h[2:0]];
        end
        return CodeNone;
    endfunction

endpackage

>>> rtl/katakana_byte_to_utf8_encoder.sv
// Top level of the JIS X0201 to UTF-8 encoder with voiced-mark merging.
//
//   Channel  | Dir | tdata                  | tlast              | tuser
//   s_       | in  | [7:0] text_byte        | -                  | -
//   m_       | out | [7:0] utf8_byte        | run_last           | -
//
// An input word is registered, decoded combinationally against the held kana
// and loaded into a four-byte result register, which sends one byte per cycle
// while m_tready is high. A word yields zero to four bytes. The next word is
// accepted while the last byte of the previous one leaves. Reset clears the
// held kana and empties both registers; m_tready low stalls the result
// register and then, through the input register, s_tready.
module katakana_byte_to_utf8_encoder (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [kbu_pkg::ByteW-1:0] s_tdata,   // [7:0] text_byte
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [kbu_pkg::ByteW-1:0] m_tdata,   // [7:0] utf8_byte
    output logic                      m_tlast
);

    logic                      in_valid_reg;
    logic                      in_valid_next;
    logic [kbu_pkg::ByteW-1:0] in_byte_reg;
    logic [kbu_pkg::ByteW-1:0] in_byte_next;
    kbu_pkg::kbu_hold_t        hold_reg;
    kbu_pkg::kbu_hold_t        hold_next;
    kbu_pkg::kbu_hold_t        hold_step;
    kbu_pkg::kbu_result_t      result;
    logic                      can_load;
    logic                      load;
    logic                      s_accept;

    assign load     = in_valid_reg && can_load;
    assign s_tready = !in_valid_reg || load;
    assign s_accept = s_tvalid && s_tready;

    kbu_step u_step (
        .text_byte (in_byte_reg),
        .hold_in   (hold_reg),
        .result    (result),
        .hold_out  (hold_step)
    );

    kbu_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .result   (result),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        hold_next     = hold_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
            in_byte_next  = s_tdata;
        end else if (load) begin
            in_valid_next = 1'b0;
        end
        // The held kana advances only when a word is decoded into the result register.
        if (load) begin
            hold_next = hold_step;
        end
    end

    always_ff @(posedge aclk) begin
        in_byte_reg <= in_byte_next;
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            hold_reg     <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            hold_reg     <= hold_next;
        end
    end

    a_held_is_kana: assert property (@(posedge aclk) disable iff (!aresetn)
        hold_reg.valid |-> kbu_pkg::is_kana(hold_reg.kana))
        else $error("held byte is not a kana");

    a_empty_hold_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !hold_reg.valid |-> (hold_reg.kana == kbu_pkg::ByteNul))
        else $error("held byte not cleared when nothing is held");

    a_pending_word_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !load) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("pending input word lost before decode");

    a_load_gives_bounded_count: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> (result.count <= kbu_pkg::CountW'(kbu_pkg::MaxResults)))
        else $error("decoded word produced too many bytes");

endmodule

>>> rtl/kbu_step.sv
// Combinational decode of one input word against the held kana.
module kbu_step (
    input  logic [kbu_pkg::ByteW-1:0] text_byte,
    input  kbu_pkg::kbu_hold_t        hold_in,
    output kbu_pkg::kbu_result_t      result,
    output kbu_pkg::kbu_hold_t        hold_out
);

    logic [kbu_pkg::CodeW-1:0] held_voiced;
    logic [kbu_pkg::CodeW-1:0] held_semi;
    logic [kbu_pkg::CodeW-1:0] held_code;
    logic [kbu_pkg::CodeW-1:0] new_code;
    logic                      take_voiced;
    logic                      take_semi;
    logic                      consumed;
    logic                      is_nul;
    logic                      is_ascii;
    logic                      new_kana;
    logic                      new_forms;
    logic                      keep_new;

    always_comb begin
        held_voiced = kbu_pkg::voiced_code(hold_in.kana);
        held_semi   = kbu_pkg::semi_code(hold_in.kana);
        take_voiced = hold_in.valid && (text_byte == kbu_pkg::MarkVoiced)
                      && (held_voiced != kbu_pkg::CodeNone);
        take_semi   = hold_in.valid && (text_byte == kbu_pkg::MarkSemi)
                      && (held_semi != kbu_pkg::CodeNone);
        consumed    = take_voiced || take_semi;

        if (take_voiced) begin
            held_code = held_voiced;
        end else if (take_semi) begin
            held_code = held_semi;
        end else begin
            held_code = kbu_pkg::base_code(hold_in.kana);
        end

        new_code  = kbu_pkg::base_code(text_byte);
        is_nul    = !consumed && (text_byte == kbu_pkg::ByteNul);
        is_ascii  = !consumed && (text_byte >= kbu_pkg::AsciiFirst)
                    && (text_byte <= kbu_pkg::AsciiLast);
        new_kana  = !consumed && kbu_pkg::is_kana(text_byte);
        new_forms = kbu_pkg::voiced_code(text_byte) != kbu_pkg::CodeNone;
        // A kana behind a flushed one is held too, so one word never exceeds four bytes.
        keep_new  = new_kana && (new_forms || hold_in.valid);

        result.bytes = '0;
        result.count = '0;
        if (hold_in.valid) begin
            result.bytes[0] = held_code[23:16];
            result.bytes[1] = held_code[15:8];
            result.bytes[2] = held_code[7:0];
            result.bytes[3] = text_byte;
            result.count    = kbu_pkg::CountW'(3);
            if (is_nul || is_ascii) begin
                result.count = kbu_pkg::CountW'(4);
            end
        end else if (is_nul || is_ascii) begin
            result.bytes[0] = text_byte;
            result.count    = kbu_pkg::CountW'(1);
        end else if (new_kana && !keep_new) begin
            result.bytes[0] = new_code[23:16];
            result.bytes[1] = new_code[15:8];
            result.bytes[2] = new_code[7:0];
            result.count    = kbu_pkg::CountW'(3);
        end

        hold_out.valid = keep_new;
        hold_out.kana  = keep_new ? text_byte : kbu_pkg::ByteNul;
    end

endmodule

>>> rtl/kbu_out_buf.sv
// Result register that sends the bytes of one input word out one at a time.
module kbu_out_buf (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      load,
    input  kbu_pkg::kbu_result_t      result,
    output logic                      can_load,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [kbu_pkg::ByteW-1:0] m_tdata,   // [7:0] utf8_byte
    output logic                      m_tlast
);

    logic [kbu_pkg::MaxResults-1:0][kbu_pkg::ByteW-1:0] data_reg;
    logic [kbu_pkg::MaxResults-1:0][kbu_pkg::ByteW-1:0] data_next;
    logic [kbu_pkg::CountW-1:0]                         count_reg;
    logic [kbu_pkg::CountW-1:0]                         count_next;
    logic                                               pop;

    assign m_tvalid = count_reg != '0;
    assign m_tdata  = data_reg[0];
    assign m_tlast  = count_reg == kbu_pkg::CountW'(1);
    assign pop      = m_tvalid && m_tready;
    // The buffer can take a new word when it is empty or its last byte leaves this cycle.
    assign can_load = (count_reg == '0) || (m_tlast && m_tready);

    always_comb begin
        data_next  = data_reg;
        count_next = count_reg;
        if (load) begin
            data_next  = result.bytes;
            count_next = result.count;
        end else if (pop) begin
            data_next  = data_reg >> kbu_pkg::ByteW;
            count_next = count_reg - kbu_pkg::CountW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule
